// File: hdl/ujf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ujf_pkg: shared types and codes of the unique job queue
// command and status codes, request and result items, per-cell control
// ----------------------------------------------------------------------------
package ujf_pkg;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_DELETE = 1'b1
  } command_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    command_t          command;
    logic [ID_W-1:0]   job_id;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   removed_job;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  // control sent to every cell of the row
  typedef struct packed {
    logic compare;  // sample the match flag against the incoming id
    logic shift;    // take the entry of the neighbour behind
    logic load;     // take the new tail id
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/ujf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ujf_cell: one slot of the job queue
// holds one id, compares it against an incoming id, shifts towards the head
// ----------------------------------------------------------------------------
module ujf_cell (
  input  wire logic                       clk,
  input  wire ujf_pkg::cell_ctrl_t        ctrl,
  input  wire logic                       occupied,
  input  wire logic [ujf_pkg::ID_W-1:0]   cmp_id,
  input  wire logic [ujf_pkg::ID_W-1:0]   load_id,
  input  wire logic [ujf_pkg::ID_W-1:0]   shift_in,
  output logic      [ujf_pkg::ID_W-1:0]   entry,
  output logic                            hit
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= shift_in;
    end else if (ctrl.load) begin
      entry <= load_id;
    end
  end

  // match flag, only meaningful for slots in use
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      hit <= occupied && (entry == cmp_id);
    end
  end

endmodule
`default_nettype wire

// File: hdl/unique_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unique_job_fifo: first-in first-out job queue that refuses duplicate ids
// a row of DEPTH cells, head at cell 0, with a compare in every cell
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// for exactly one cycle, and no new command is taken until it drops. When a
// command is taken every cell compares the incoming id with its own entry and
// registers a match flag; while busy is high the flags are or-ed, the command
// is resolved, the row is updated and the result is registered. The result
// appears on result with result_valid high for one cycle, the first cycle in
// which busy is low again, and must be taken then: there is no way to hold it
// off. A duplicate id is reported before a full queue. Busy is also high
// during reset. Capacity is written through cfg_*; cfg_ready is low while busy
// is high, so a write never lands on a pending command. Capacity above DEPTH
// acts as DEPTH, and capacity 0 refuses every add that is not a duplicate.
// Delete on an empty queue reports empty and changes nothing. No clearing
// pass after reset: slots beyond the count are never read.
// ----------------------------------------------------------------------------
module unique_job_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire ujf_pkg::request_t             request,
  // result strobe
  output logic                               result_valid,
  output ujf_pkg::result_t                   result,
  // capacity register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ujf_pkg::CAP_W-1:0]     cfg_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // width wide enough to compare the count with the capacity register
  localparam int unsigned CMP_W = (CNT_W > ujf_pkg::CAP_W) ? CNT_W : ujf_pkg::CAP_W;

  logic                       accept;
  logic                       pending;
  ujf_pkg::command_t          command_q;
  logic [ujf_pkg::ID_W-1:0]   job_id_q;
  logic [ujf_pkg::CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;

  logic [ujf_pkg::ID_W-1:0]   entries [DEPTH];
  logic [DEPTH-1:0]           hits;
  ujf_pkg::cell_ctrl_t        ctrl [DEPTH];

  logic                       dup;
  logic                       full;
  logic                       do_add;
  logic                       do_del;
  ujf_pkg::result_t           result_next;

  assign accept    = start && !busy;
  assign busy      = pending || rst;
  assign cfg_ready = !busy;

  // capacity register, written only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ujf_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      command_q <= request.command;
      job_id_q  <= request.job_id;
    end
  end

  // resolve the command from the registered match flags
  assign dup  = |hits;
  assign full = (CMP_W'(count) >= CMP_W'(capacity)) || (count >= CNT_W'(DEPTH));

  always_comb begin
    do_add      = 1'b0;
    do_del      = 1'b0;
    count_next  = count;
    result_next.removed_job = '0;
    if (command_q == ujf_pkg::CMD_ADD) begin
      if (dup) begin
        result_next.status = ujf_pkg::ST_DUPLICATE;
      end else if (full) begin
        result_next.status = ujf_pkg::ST_FULL;
      end else begin
        result_next.status = ujf_pkg::ST_ADDED;
        do_add     = pending;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (count == '0) begin
        result_next.status = ujf_pkg::ST_EMPTY;
      end else begin
        result_next.status      = ujf_pkg::ST_DELETED;
        result_next.removed_job = entries[0];
        do_del     = pending;
        count_next = count - CNT_W'(1);
      end
    end
    result_next.occupancy = ujf_pkg::OCC_W'(count_next);
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_add || do_del) begin
      count <= count_next;
    end
  end

  // result strobe, registered from pending, in the cycle after the resolve cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      result <= result_next;
    end
  end

  // the row of cells; a delete moves every entry one place towards the head,
  // an add writes the slot just past the last held job
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ujf_pkg::ID_W-1:0] behind;

    if (i == DEPTH - 1) begin : g_last
      assign behind = '0;
    end else begin : g_mid
      assign behind = entries[i+1];
    end

    assign ctrl[i].compare = accept;
    assign ctrl[i].shift   = do_del;
    assign ctrl[i].load    = do_add && (count == CNT_W'(i));

    ujf_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .occupied (count > CNT_W'(i)),
      .cmp_id   (request.job_id),
      .load_id  (job_id_q),
      .shift_in (behind),
      .entry    (entries[i]),
      .hit      (hits[i])
    );
  end

endmodule
`default_nettype wire
